[hw/rtl/rigt_pkg.sv]
// Shared types and constants for the range image grid triangulator.
// No dependencies; used by every module of the block.
package rigt_pkg;

    localparam int unsigned MAX_COLS_DEF = 1024;
    localparam int unsigned MAX_ROWS_DEF = 1024;

    localparam int unsigned IDX_W   = 20;
    localparam int unsigned DEPTH_W = 32;
    localparam int unsigned DIM_W   = 11;
    // magnitude of a difference of two Q16.16 depths
    localparam int unsigned MAG_W   = DEPTH_W + 1;

    localparam logic [DIM_W-1:0] COLS_RST = DIM_W'(640);
    localparam logic [DIM_W-1:0] ROWS_RST = DIM_W'(480);

    typedef enum logic {
        CFG_IMAGE_COLS = 1'b0,
        CFG_IMAGE_ROWS = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] index;
        logic [DEPTH_W-1:0] depth;
    } pix_t;

    typedef struct packed {
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
        logic [IDX_W-1:0] c;
        logic             last;
    } tri_t;

    typedef struct packed {
        logic [1:0] ntri;
        tri_t       t0;
        tri_t       t1;
    } cell_res_t;

endpackage

[hw/rtl/rigt_line_store.sv]
// Previous-row line store: one synchronous RAM, read-first, registered read data.
// Depends on rigt_pkg (pix_t).
module rigt_line_store #(
    parameter int unsigned DEPTH_N = rigt_pkg::MAX_COLS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       acc,
    input  logic [$clog2(DEPTH_N)-1:0] col,
    input  rigt_pkg::pix_t             wr_pix,
    output rigt_pkg::pix_t             rd_pix
);

    localparam int unsigned COL_W = $clog2(DEPTH_N);
    localparam int unsigned PIX_W = $bits(rigt_pkg::pix_t);

    logic [PIX_W-1:0] mem [DEPTH_N];
    logic [PIX_W-1:0] rd_reg;
    // entries below the high-water mark have been written since reset
    logic [COL_W:0]   hw_reg;
    logic [COL_W:0]   hw_next;
    logic             hit_reg;
    logic             hit_next;

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            rd_reg   <= mem[col];
            mem[col] <= wr_pix;
        end
    end

    always_comb
    begin
        hw_next  = hw_reg;
        hit_next = hit_reg;
        if (acc)
        begin
            hit_next = {1'b0, col} < hw_reg;
            if ({1'b0, col} >= hw_reg)
                hw_next = {1'b0, col} + (COL_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hw_reg  <= '0;
            hit_reg <= 1'b0;
        end
        else
        begin
            hw_reg  <= hw_next;
            hit_reg <= hit_next;
        end
    end

    assign rd_pix = hit_reg ? rigt_pkg::pix_t'(rd_reg) : '0;

endmodule

[hw/rtl/rigt_cell_eval.sv]
// Cell evaluation: neighbour registers, depth difference stage and triangle selection.
// Depends on rigt_pkg (pix_t, tri_t, cell_res_t).
module rigt_cell_eval (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                ld,
    input  rigt_pkg::pix_t      cur_in,
    input  logic                cell_in,
    input  rigt_pkg::pix_t      up_pix,
    output logic                s1_ready,
    output logic                res_valid,
    output rigt_pkg::cell_res_t res,
    input  logic                res_ready
);

    localparam int unsigned MAG_W = rigt_pkg::MAG_W;
    localparam int unsigned IDX_W = rigt_pkg::IDX_W;
    localparam int unsigned DEP_W = rigt_pkg::DEPTH_W;

    function automatic logic [MAG_W-1:0] abs_diff(
        input logic [DEP_W-1:0] x,
        input logic [DEP_W-1:0] y
    );
        logic signed [MAG_W-1:0] dxy;
        logic signed [MAG_W-1:0] dyx;
        dxy = $signed({x[DEP_W-1], x}) - $signed({y[DEP_W-1], y});
        dyx = $signed({y[DEP_W-1], y}) - $signed({x[DEP_W-1], x});
        return dxy[MAG_W-1] ? $unsigned(dyx) : $unsigned(dxy);
    endfunction

    function automatic rigt_pkg::tri_t mk_tri(
        input logic [IDX_W-1:0] a,
        input logic [IDX_W-1:0] b,
        input logic [IDX_W-1:0] c
    );
        rigt_pkg::tri_t t;
        t.a    = a;
        t.b    = b;
        t.c    = c;
        t.last = 1'b0;
        return t;
    endfunction

    // stage 1: current pixel waiting for the line store word
    logic           s1_valid_reg;
    logic           s1_valid_next;
    rigt_pkg::pix_t s1_cur_reg;
    logic           s1_cell_reg;
    // corners 1 and 3 for the pixel now in stage 1
    rigt_pkg::pix_t ul_reg;
    rigt_pkg::pix_t left_reg;
    // stage 2: corner flags, indices and diagonal magnitudes
    logic             s2_valid_reg;
    logic             s2_valid_next;
    logic             s2_cell_reg;
    logic [3:0]       s2_v_reg;
    logic [IDX_W-1:0] s2_i1_reg;
    logic [IDX_W-1:0] s2_i2_reg;
    logic [IDX_W-1:0] s2_i3_reg;
    logic [IDX_W-1:0] s2_i4_reg;
    logic [MAG_W-1:0] s2_m14_reg;
    logic [MAG_W-1:0] s2_m23_reg;

    logic s1_fire;
    logic s2_ready;
    logic s2_go;
    logic split23;

    assign s2_go         = (res.ntri == 2'd0) || res_ready;
    assign s2_ready      = !s2_valid_reg || s2_go;
    assign s1_ready      = !s1_valid_reg || s2_ready;
    assign s1_fire       = s1_valid_reg && s2_ready;
    assign s1_valid_next = s1_ready ? ld : s1_valid_reg;
    assign s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            ul_reg       <= '0;
            left_reg     <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            if (s1_fire)
            begin
                ul_reg   <= up_pix;
                left_reg <= s1_cur_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld && s1_ready)
        begin
            s1_cur_reg  <= cur_in;
            s1_cell_reg <= cell_in;
        end
        if (s1_fire)
        begin
            s2_cell_reg <= s1_cell_reg;
            s2_v_reg    <= {ul_reg.valid, up_pix.valid, left_reg.valid, s1_cur_reg.valid};
            s2_i1_reg   <= ul_reg.index;
            s2_i2_reg   <= up_pix.index;
            s2_i3_reg   <= left_reg.index;
            s2_i4_reg   <= s1_cur_reg.index;
            s2_m14_reg  <= abs_diff(ul_reg.depth, s1_cur_reg.depth);
            s2_m23_reg  <= abs_diff(up_pix.depth, left_reg.depth);
        end
    end

    // ties go to the 1-4 diagonal
    assign split23 = s2_m14_reg > s2_m23_reg;

    always_comb
    begin
        res.ntri = 2'd0;
        res.t0   = '0;
        res.t1   = '0;
        // v bits: corner 1, 2, 3, 4 from the top down
        case (s2_v_reg)
            4'b1111:
            begin
                res.ntri = 2'd2;
                if (split23)
                begin
                    res.t0 = mk_tri(s2_i1_reg, s2_i3_reg, s2_i2_reg);
                    res.t1 = mk_tri(s2_i2_reg, s2_i3_reg, s2_i4_reg);
                end
                else
                begin
                    res.t0 = mk_tri(s2_i1_reg, s2_i3_reg, s2_i4_reg);
                    res.t1 = mk_tri(s2_i1_reg, s2_i4_reg, s2_i2_reg);
                end
            end
            4'b0111:
            begin
                res.ntri = 2'd1;
                res.t0   = mk_tri(s2_i2_reg, s2_i3_reg, s2_i4_reg);
            end
            4'b1011:
            begin
                res.ntri = 2'd1;
                res.t0   = mk_tri(s2_i1_reg, s2_i3_reg, s2_i4_reg);
            end
            4'b1101:
            begin
                res.ntri = 2'd1;
                res.t0   = mk_tri(s2_i1_reg, s2_i4_reg, s2_i2_reg);
            end
            4'b1110:
            begin
                res.ntri = 2'd1;
                res.t0   = mk_tri(s2_i1_reg, s2_i3_reg, s2_i2_reg);
            end
            default:
            begin
                res.ntri = 2'd0;
            end
        endcase
        if (!s2_valid_reg || !s2_cell_reg)
            res.ntri = 2'd0;
        res.t0.last = (res.ntri == 2'd1);
        res.t1.last = 1'b1;
    end

    assign res_valid = s2_valid_reg && (res.ntri != 2'd0);

endmodule

[hw/rtl/rigt_tri_queue.sv]
// Two-slot result buffer: holds the triangles of one cell and issues one word per cycle
// while out_stall is low. Depends on rigt_pkg (tri_t, cell_res_t).
module rigt_tri_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                res_valid,
    input  rigt_pkg::cell_res_t res,
    output logic                res_ready,
    output logic                out_valid,
    input  logic                out_stall,
    output rigt_pkg::tri_t      out_tri
);

    logic [1:0]     cnt_reg;
    logic [1:0]     cnt_next;
    rigt_pkg::tri_t slot0_reg;
    rigt_pkg::tri_t slot0_next;
    rigt_pkg::tri_t slot1_reg;
    rigt_pkg::tri_t slot1_next;
    logic           take;
    logic           load;

    assign out_valid = cnt_reg != 2'd0;
    assign take      = out_valid && !out_stall;
    assign res_ready = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && take);
    assign load      = res_valid && res_ready;
    assign out_tri   = slot0_reg;

    always_comb
    begin
        cnt_next   = cnt_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (load)
        begin
            cnt_next   = res.ntri;
            slot0_next = res.t0;
            slot1_next = res.t1;
        end
        else if (take)
        begin
            cnt_next   = cnt_reg - 2'd1;
            slot0_next = slot1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

[hw/rtl/range_image_grid_triangulator_core.sv]
// Range image grid triangulator, top level: config, raster counters, vertex numbering.
// Throughput: one pixel per cycle while out_stall is low and each pixel yields at most
// one triangle; the single result word port sends a pair in turn and can stall input.
// Reset: counters and pipeline valids clear and config takes its reset values at once;
// the line store RAM is not swept, a high-water mark makes unwritten entries read as
// invalid. Depends on rigt_*.
module range_image_grid_triangulator_core #(
    parameter int unsigned MAX_COLS = rigt_pkg::MAX_COLS_DEF,
    parameter int unsigned MAX_ROWS = rigt_pkg::MAX_ROWS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                pixel_valid,
    input  logic signed [rigt_pkg::DEPTH_W-1:0] depth,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [rigt_pkg::IDX_W-1:0]          corner_a,
    output logic [rigt_pkg::IDX_W-1:0]          corner_b,
    output logic [rigt_pkg::IDX_W-1:0]          corner_c,
    output logic                                last_of_cell,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic                                cfg_index,
    input  logic [rigt_pkg::DIM_W-1:0]          cfg_data
);

    localparam int unsigned DIM_W = rigt_pkg::DIM_W;
    localparam int unsigned IDX_W = rigt_pkg::IDX_W;
    localparam int unsigned COL_W = $clog2(MAX_COLS);
    localparam int unsigned ROW_W = $clog2(MAX_ROWS);
    localparam int unsigned POS_W = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int unsigned CMP_W = ((POS_W > DIM_W) ? POS_W : DIM_W) + 1;
    localparam logic [CMP_W-1:0] MAX_C = CMP_W'(MAX_COLS);
    localparam logic [CMP_W-1:0] MAX_R = CMP_W'(MAX_ROWS);
    localparam logic [CMP_W-1:0] MIN_D = CMP_W'(2);

    logic [DIM_W-1:0] cols_cfg_reg;
    logic [DIM_W-1:0] rows_cfg_reg;
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic [IDX_W-1:0] vcount_reg;
    logic [IDX_W-1:0] vcount_next;

    logic [CMP_W-1:0] cols_raw;
    logic [CMP_W-1:0] rows_raw;
    logic [CMP_W-1:0] cols_eff;
    logic [CMP_W-1:0] rows_eff;
    logic             wrap_col;
    logic             wrap_row;
    logic             in_acc;
    logic             s1_ready;
    logic             in_cell;
    rigt_pkg::pix_t   cur;
    rigt_pkg::pix_t   up_pix;
    logic             res_valid;
    logic             res_ready;
    rigt_pkg::cell_res_t res;
    rigt_pkg::tri_t   out_tri;

    // configuration words
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_cfg_reg <= rigt_pkg::COLS_RST;
            rows_cfg_reg <= rigt_pkg::ROWS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (rigt_pkg::cfg_reg_t'(cfg_index))
                rigt_pkg::CFG_IMAGE_COLS: cols_cfg_reg <= cfg_data;
                rigt_pkg::CFG_IMAGE_ROWS: rows_cfg_reg <= cfg_data;
            endcase
        end
    end

    assign cols_raw = CMP_W'(cols_cfg_reg);
    assign rows_raw = CMP_W'(rows_cfg_reg);
    assign cols_eff = (cols_raw < MIN_D) ? MIN_D : ((cols_raw > MAX_C) ? MAX_C : cols_raw);
    assign rows_eff = (rows_raw < MIN_D) ? MIN_D : ((rows_raw > MAX_R) ? MAX_R : rows_raw);

    assign in_stall = !s1_ready;
    assign in_acc   = in_valid && !in_stall;

    // a position at or past a lowered limit wraps on its next advance
    assign wrap_col = (CMP_W'(col_reg) + CMP_W'(1)) >= cols_eff;
    assign wrap_row = (CMP_W'(row_reg) + CMP_W'(1)) >= rows_eff;
    assign in_cell  = (col_reg != '0) && (row_reg != '0);

    assign cur.valid = pixel_valid;
    assign cur.index = pixel_valid ? vcount_reg : '0;
    assign cur.depth = pixel_valid ? $unsigned(depth) : '0;

    always_comb
    begin
        col_next    = col_reg;
        row_next    = row_reg;
        vcount_next = vcount_reg;
        if (in_acc)
        begin
            vcount_next = vcount_reg + IDX_W'(pixel_valid);
            if (wrap_col)
            begin
                col_next = '0;
                if (wrap_row)
                begin
                    row_next    = '0;
                    vcount_next = '0;
                end
                else
                begin
                    row_next = row_reg + ROW_W'(1);
                end
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            vcount_reg <= '0;
        end
        else
        begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            vcount_reg <= vcount_next;
        end
    end

    rigt_line_store #(
        .DEPTH_N (MAX_COLS)
    ) u_line_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .acc    (in_acc),
        .col    (col_reg),
        .wr_pix (cur),
        .rd_pix (up_pix)
    );

    rigt_cell_eval u_cell_eval (
        .clk       (clk),
        .rst_n     (rst_n),
        .ld        (in_acc),
        .cur_in    (cur),
        .cell_in   (in_cell),
        .up_pix    (up_pix),
        .s1_ready  (s1_ready),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready)
    );

    rigt_tri_queue u_tri_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_tri   (out_tri)
    );

    assign corner_a     = out_tri.a;
    assign corner_b     = out_tri.b;
    assign corner_c     = out_tri.c;
    assign last_of_cell = out_tri.last;

`ifndef SYNTHESIS
    // the first triangle of a pair is always followed by its partner
    a_pair_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_cell |=> out_valid)
        else $error("second triangle of cell missing");

    a_pair_next: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_of_cell |=> out_valid && last_of_cell)
        else $error("word after first triangle is not the closing one");

    // raster column advances by one or wraps to zero
    a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (col_reg == '0) || (col_reg == $past(col_reg) + COL_W'(1)))
        else $error("column position jumped");
`endif

endmodule
